@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL of the exact stamp pair matcher.
// The macros sample on clk and are disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ESPM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ESPM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/espm_pkg.sv @@
// Package for the exact stamp pair matcher: widths, register map, cell opcodes
// and the control and status bundles passed between the sequencer and the chains.
// No dependencies.
`timescale 1ns / 1ps

package espm_pkg;

	localparam int STAMP_W       = 63;
	localparam int CFG_W         = 7;
	localparam int DROP_CNT_W    = 7;
	localparam int DEPTH_DEFAULT = 64;
	localparam int PADDR_W       = 3;
	localparam int PDATA_W       = 32;

	localparam logic [CFG_W-1:0]      MAX_HELD_RESET = 7'd64;
	localparam logic [DROP_CNT_W-1:0] DROP_CNT_MAX   = 7'd127;

	// Register index, taken from paddr[2].
	localparam logic REG_MAX_HELD = 1'b0;

	typedef enum logic [1:0] {
		OP_NOP,
		OP_INSERT,
		OP_REMOVE,
		OP_SHIFT
	} cell_op_t;

	typedef struct packed {
		cell_op_t             op;
		logic [STAMP_W-1:0]   key;
	} chain_ctl_t;

	typedef struct packed {
		logic                 hit;
		logic                 head_valid;
		logic [STAMP_W-1:0]   head_stamp;
	} chain_stat_t;

endpackage

@@ rtl/core/espm_cell.sv @@
// One cell of a sorted stamp chain: holds one stamp and its used bit.
// Depends on espm_pkg.
`timescale 1ns / 1ps

module espm_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  espm_pkg::chain_ctl_t        ctl,
	input  logic [espm_pkg::STAMP_W-1:0] prev_stamp,
	input  logic                        prev_valid,
	input  logic                        prev_gt,
	input  logic [espm_pkg::STAMP_W-1:0] next_stamp,
	input  logic                        next_valid,
	output logic [espm_pkg::STAMP_W-1:0] stamp_q,
	output logic                        valid_q,
	output logic                        gt,
	output logic                        eq
);

	logic ge;

	// An empty cell counts as holding a stamp above every key.
	assign gt = !valid_q || (stamp_q > ctl.key);
	assign ge = valid_q && (stamp_q >= ctl.key);
	assign eq = valid_q && (stamp_q == ctl.key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			unique case (ctl.op)
				espm_pkg::OP_INSERT: valid_q <= prev_valid;
				espm_pkg::OP_REMOVE: begin
					if (ge) begin
						valid_q <= next_valid;
					end
				end
				espm_pkg::OP_SHIFT:  valid_q <= next_valid;
				default:             valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			espm_pkg::OP_INSERT: begin
				if (prev_gt) begin
					stamp_q <= prev_stamp;
				end else if (gt) begin
					stamp_q <= ctl.key;
				end
			end
			espm_pkg::OP_REMOVE: begin
				if (ge) begin
					stamp_q <= next_stamp;
				end
			end
			espm_pkg::OP_SHIFT:  stamp_q <= next_stamp;
			default:             stamp_q <= stamp_q;
		endcase
	end

endmodule

@@ rtl/core/espm_chain.sv @@
// A row of cells holding one stream's stamps, packed and sorted ascending.
// Depends on espm_pkg and espm_cell.
`timescale 1ns / 1ps

module espm_chain #(
	parameter int DEPTH = espm_pkg::DEPTH_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  espm_pkg::chain_ctl_t  ctl,
	output espm_pkg::chain_stat_t stat
);

	logic [espm_pkg::STAMP_W-1:0] stamp_w      [DEPTH];
	logic [espm_pkg::STAMP_W-1:0] prev_stamp_w [DEPTH];
	logic [espm_pkg::STAMP_W-1:0] next_stamp_w [DEPTH];
	logic [DEPTH-1:0]             valid_w;
	logic [DEPTH-1:0]             gt_w;
	logic [DEPTH-1:0]             eq_w;
	logic [DEPTH-1:0]             prev_valid_w;
	logic [DEPTH-1:0]             prev_gt_w;
	logic [DEPTH-1:0]             next_valid_w;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign prev_stamp_w[i] = '0;
			assign prev_valid_w[i] = 1'b1;
			assign prev_gt_w[i]    = 1'b0;
		end else begin : g_mid
			assign prev_stamp_w[i] = stamp_w[i-1];
			assign prev_valid_w[i] = valid_w[i-1];
			assign prev_gt_w[i]    = gt_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign next_stamp_w[i] = '0;
			assign next_valid_w[i] = 1'b0;
		end else begin : g_inner
			assign next_stamp_w[i] = stamp_w[i+1];
			assign next_valid_w[i] = valid_w[i+1];
		end

		espm_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.prev_stamp (prev_stamp_w[i]),
			.prev_valid (prev_valid_w[i]),
			.prev_gt    (prev_gt_w[i]),
			.next_stamp (next_stamp_w[i]),
			.next_valid (next_valid_w[i]),
			.stamp_q    (stamp_w[i]),
			.valid_q    (valid_w[i]),
			.gt         (gt_w[i]),
			.eq         (eq_w[i])
		);
	end

	assign stat.hit        = |eq_w;
	assign stat.head_valid = valid_w[0];
	assign stat.head_stamp = stamp_w[0];

endmodule

@@ rtl/core/exact_stamp_pair_matcher.sv @@
// Exact stamp pair matcher: top level with the APB register, the item sequencer and two cell chains.
// Each item passes LOOKUP, ACT and TRIM, with REFILL after ACT when a full table gives up its head
// to make room; TRIM pops one stamp per step until the limit holds. An invalid pose passes DONE.
// The next input beat is taken the cycle after the result is loaded into the output register, so
// the sequencer handles one item at a time; the load waits until the output register is free.
// Reset (arst_n, asynchronous, low): both tables empty at once, max_held = 64, no result pending.
`timescale 1ns / 1ps

module exact_stamp_pair_matcher #(
	parameter int DEPTH = espm_pkg::DEPTH_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// APB configuration port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [espm_pkg::PADDR_W-1:0]     paddr,
	input  logic [espm_pkg::PDATA_W-1:0]     pwdata,
	output logic [espm_pkg::PDATA_W-1:0]     prdata,
	output logic                             pready,
	// Input channel
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             action,
	input  logic [espm_pkg::STAMP_W-1:0]     stamp,
	input  logic                             pose_valid,
	// Result channel
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             inserted,
	output logic                             matched,
	output logic [espm_pkg::DROP_CNT_W-1:0]  dropped_count,
	output logic [espm_pkg::STAMP_W-1:0]     first_drop
);

	`include "assert_macros.svh"

	// Count width holds 0..DEPTH; the limit is compared at the wider of that and the register.
	localparam int CW = $clog2(DEPTH + 1);
	localparam int LW = (CW > espm_pkg::CFG_W) ? CW : espm_pkg::CFG_W;

	// Sequencer states. LOOKUP registers the search of both tables, ACT applies the
	// match, insert or full-table replacement, REFILL inserts after a full table gave
	// up its head, TRIM pops the smallest stamp each cycle until the limit holds and
	// then loads the result. DONE loads the all-zero result of an invalid pose.
	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_LOOKUP = 6'b000010,
		ST_ACT    = 6'b000100,
		ST_REFILL = 6'b001000,
		ST_TRIM   = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	state_t                            state_q;
	logic [espm_pkg::CFG_W-1:0]        max_held_q;
	logic [CW-1:0]                     pose_cnt_q;
	logic [CW-1:0]                     scan_cnt_q;

	// Per-item working registers.
	logic                              is_scan_q;
	logic [espm_pkg::STAMP_W-1:0]      key_q;
	logic                              own_hit_q;
	logic                              oth_hit_q;
	logic                              matched_q;
	logic [espm_pkg::DROP_CNT_W-1:0]   drops_q;
	logic [espm_pkg::STAMP_W-1:0]      first_q;

	// Output register.
	logic                              out_valid_q;
	logic                              inserted_q;
	logic                              out_matched_q;
	logic [espm_pkg::DROP_CNT_W-1:0]   out_drops_q;
	logic [espm_pkg::STAMP_W-1:0]      out_first_q;

	espm_pkg::chain_ctl_t              pose_ctl;
	espm_pkg::chain_ctl_t              scan_ctl;
	espm_pkg::chain_stat_t             pose_stat;
	espm_pkg::chain_stat_t             scan_stat;
	espm_pkg::chain_stat_t             own_stat;
	espm_pkg::chain_stat_t             oth_stat;
	espm_pkg::cell_op_t                own_op;
	espm_pkg::cell_op_t                oth_op;

	logic [CW-1:0]                     own_cnt;
	logic [LW-1:0]                     mh_ext;
	logic [LW-1:0]                     limit_ext;
	logic [CW-1:0]                     limit;
	logic                              over_limit;
	logic                              own_full;
	logic                              key_below_head;
	logic                              out_free;
	logic                              load_out;
	logic                              cfg_wr;

	//------------------------------------------------------------------
	// Configuration port. Only max_held exists; a write with paddr[2]
	// set falls outside the register map and is ignored.
	//------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == espm_pkg::REG_MAX_HELD) ?
		{{(espm_pkg::PDATA_W - espm_pkg::CFG_W){1'b0}}, max_held_q} : '0;

	//------------------------------------------------------------------
	// Table selection. The arriving stream's table is "own", the other
	// stream's table is "oth"; both chains see the same key.
	//------------------------------------------------------------------
	assign own_stat = is_scan_q ? scan_stat : pose_stat;
	assign oth_stat = is_scan_q ? pose_stat : scan_stat;
	assign own_cnt  = is_scan_q ? scan_cnt_q : pose_cnt_q;

	// The effective limit is max_held clamped to the range 2 to DEPTH.
	assign mh_ext = LW'(max_held_q);
	always_comb begin
		priority if (mh_ext < LW'(2)) begin
			limit_ext = LW'(2);
		end else if (mh_ext > LW'(DEPTH)) begin
			limit_ext = LW'(DEPTH);
		end else begin
			limit_ext = mh_ext;
		end
	end
	assign limit = CW'(limit_ext);

	assign over_limit     = own_cnt > limit;
	assign own_full       = own_cnt == CW'(DEPTH);
	assign key_below_head = key_q < own_stat.head_stamp;
	assign out_free       = !out_valid_q || out_ready;
	assign load_out       = ((state_q == ST_TRIM) && !over_limit && out_free)
		|| ((state_q == ST_DONE) && out_free);

	//------------------------------------------------------------------
	// Chain commands for this cycle.
	//------------------------------------------------------------------
	always_comb begin
		own_op = espm_pkg::OP_NOP;
		oth_op = espm_pkg::OP_NOP;
		unique case (state_q)
			ST_ACT: begin
				if (oth_hit_q) begin
					// A pair: the stamp leaves both tables.
					oth_op = espm_pkg::OP_REMOVE;
					if (own_hit_q) begin
						own_op = espm_pkg::OP_REMOVE;
					end
				end else if (!own_hit_q) begin
					if (!own_full) begin
						own_op = espm_pkg::OP_INSERT;
					end else if (!key_below_head) begin
						// Full table and the new stamp is not the smallest:
						// the head is dropped first and the stamp inserted next cycle.
						own_op = espm_pkg::OP_SHIFT;
					end
				end
			end
			ST_REFILL: own_op = espm_pkg::OP_INSERT;
			ST_TRIM: begin
				if (over_limit) begin
					own_op = espm_pkg::OP_SHIFT;
				end
			end
			default: begin
				own_op = espm_pkg::OP_NOP;
				oth_op = espm_pkg::OP_NOP;
			end
		endcase
	end

	assign pose_ctl.op  = is_scan_q ? oth_op : own_op;
	assign pose_ctl.key = key_q;
	assign scan_ctl.op  = is_scan_q ? own_op : oth_op;
	assign scan_ctl.key = key_q;

	espm_chain #(
		.DEPTH (DEPTH)
	) u_pose_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (pose_ctl),
		.stat   (pose_stat)
	);

	espm_chain #(
		.DEPTH (DEPTH)
	) u_scan_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (scan_ctl),
		.stat   (scan_stat)
	);

	//------------------------------------------------------------------
	// Control registers: state, fill counts, configuration, result valid.
	// The fill counts follow the command given to each chain.
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			max_held_q  <= espm_pkg::MAX_HELD_RESET;
			pose_cnt_q  <= '0;
			scan_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr && (paddr[2] == espm_pkg::REG_MAX_HELD)) begin
				max_held_q <= pwdata[espm_pkg::CFG_W-1:0];
			end

			unique case (pose_ctl.op)
				espm_pkg::OP_INSERT: pose_cnt_q <= CW'(pose_cnt_q + 1'b1);
				espm_pkg::OP_REMOVE,
				espm_pkg::OP_SHIFT:  pose_cnt_q <= CW'(pose_cnt_q - 1'b1);
				default:             pose_cnt_q <= pose_cnt_q;
			endcase

			unique case (scan_ctl.op)
				espm_pkg::OP_INSERT: scan_cnt_q <= CW'(scan_cnt_q + 1'b1);
				espm_pkg::OP_REMOVE,
				espm_pkg::OP_SHIFT:  scan_cnt_q <= CW'(scan_cnt_q - 1'b1);
				default:             scan_cnt_q <= scan_cnt_q;
			endcase

			out_valid_q <= load_out || (out_valid_q && !out_ready);

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= (!action && !pose_valid) ? ST_DONE : ST_LOOKUP;
					end
				end
				ST_LOOKUP: state_q <= ST_ACT;
				ST_ACT: begin
					if (!oth_hit_q && !own_hit_q && own_full && !key_below_head) begin
						state_q <= ST_REFILL;
					end else begin
						state_q <= ST_TRIM;
					end
				end
				ST_REFILL: state_q <= ST_TRIM;
				ST_TRIM: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	//------------------------------------------------------------------
	// Item and result payload registers.
	//------------------------------------------------------------------
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					is_scan_q <= action;
					key_q     <= stamp;
					matched_q <= 1'b0;
					drops_q   <= '0;
					first_q   <= '0;
				end
			end
			ST_LOOKUP: begin
				own_hit_q <= own_stat.hit;
				oth_hit_q <= oth_stat.hit;
			end
			ST_ACT: begin
				if (oth_hit_q) begin
					matched_q <= 1'b1;
				end else if (!own_hit_q && own_full) begin
					// One of DEPTH+1 stamps goes: the new one if it is the smallest,
					// else the current head.
					drops_q <= espm_pkg::DROP_CNT_W'(1);
					first_q <= key_below_head ? key_q : own_stat.head_stamp;
				end
			end
			ST_TRIM: begin
				if (over_limit) begin
					if (drops_q != espm_pkg::DROP_CNT_MAX) begin
						drops_q <= espm_pkg::DROP_CNT_W'(drops_q + 1'b1);
					end
					if (drops_q == '0) begin
						first_q <= own_stat.head_stamp;
					end
				end
			end
			default: begin
				key_q <= key_q;
			end
		endcase

		if (load_out) begin
			inserted_q    <= (state_q == ST_TRIM);
			out_matched_q <= matched_q;
			out_drops_q   <= drops_q;
			out_first_q   <= first_q;
		end
	end

	assign in_ready      = (state_q == ST_IDLE);
	assign out_valid     = out_valid_q;
	assign inserted      = inserted_q;
	assign matched       = out_matched_q;
	assign dropped_count = out_drops_q;
	assign first_drop    = out_first_q;

	//------------------------------------------------------------------
	// Assertions
	//------------------------------------------------------------------
	// The chains stay packed: the head cell is used exactly when the count is nonzero.
	`ESPM_ASSERT_IMP(a_pose_head_cnt, 1'b1, pose_stat.head_valid == (pose_cnt_q != '0), "pose chain head disagrees with fill count")
	`ESPM_ASSERT_IMP(a_scan_head_cnt, 1'b1, scan_stat.head_valid == (scan_cnt_q != '0), "scan chain head disagrees with fill count")
	// A full table that gave up its head is full again after the refill.
	`ESPM_ASSERT_NXT(a_refill_full, state_q == ST_REFILL, (is_scan_q ? scan_cnt_q : pose_cnt_q) == CW'(DEPTH), "table not full after refill")

endmodule

@@ sim/stamp_pair_checker.sv @@
// Checker for the exact stamp pair matcher. It mirrors both stamp tables and max_held,
// predicts one outcome per input beat and compares it with each result beat.
// Depends on espm_pkg.
`timescale 1ns / 1ps

module stamp_pair_checker #(
	parameter int DEPTH = espm_pkg::DEPTH_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [espm_pkg::PADDR_W-1:0]     paddr,
	input  logic [espm_pkg::PDATA_W-1:0]     pwdata,
	input  logic [espm_pkg::PDATA_W-1:0]     prdata,
	input  logic                             pready,
	input  logic                             in_valid,
	input  logic                             in_ready,
	input  logic                             action,
	input  logic [espm_pkg::STAMP_W-1:0]     stamp,
	input  logic                             pose_valid,
	input  logic                             out_valid,
	input  logic                             out_ready,
	input  logic                             inserted,
	input  logic                             matched,
	input  logic [espm_pkg::DROP_CNT_W-1:0]  dropped_count,
	input  logic [espm_pkg::STAMP_W-1:0]     first_drop,
	output int                               mismatches,
	output int                               awaiting
);
	import espm_pkg::*;

	typedef struct packed {
		logic                  ins;
		logic                  mat;
		logic [DROP_CNT_W-1:0] dcount;
		logic [STAMP_W-1:0]    dstamp;
	} pair_outcome_t;

	// Side 0 holds pose stamps, side 1 scan stamps.
	logic [STAMP_W-1:0] stamp_tab [2][DEPTH];
	bit                 slot_used [2][DEPTH];
	logic [CFG_W-1:0]   held_limit;
	pair_outcome_t      outcomes_q [$];

	task automatic flag_mismatch(input string what, input logic [63:0] want,
		input logic [63:0] got);
		mismatches++;
		$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
	endtask

	// Enters the stamp, pairs it against the other side and trims the arriving side.
	function automatic pair_outcome_t pair_and_trim(input logic is_scan,
		input logic [STAMP_W-1:0] s, input logic valid);
		pair_outcome_t      res;
		int                 own, oth, own_i, oth_i, slot, m, cnt, lim, drops, i;
		bit                 pending;
		logic [STAMP_W-1:0] d;
		res = '0;
		if (!is_scan && !valid)
			return res;
		own = is_scan ? 1 : 0;
		oth = 1 - own;
		lim = int'(held_limit);
		if (lim < 2)
			lim = 2;
		if (lim > DEPTH)
			lim = DEPTH;
		own_i = -1;
		oth_i = -1;
		slot = -1;
		pending = 1'b0;
		drops = 0;
		for (i = 0; i < DEPTH; i++) begin
			if (own_i < 0 && slot_used[own][i] && stamp_tab[own][i] == s)
				own_i = i;
			if (oth_i < 0 && slot_used[oth][i] && stamp_tab[oth][i] == s)
				oth_i = i;
		end
		res.ins = 1'b1;
		if (oth_i >= 0) begin
			res.mat = 1'b1;
			slot_used[oth][oth_i] = 1'b0;
			if (own_i >= 0)
				slot_used[own][own_i] = 1'b0;
		end else if (own_i < 0) begin
			for (i = 0; i < DEPTH; i++)
				if (slot < 0 && !slot_used[own][i])
					slot = i;
			if (slot >= 0) begin
				stamp_tab[own][slot] = s;
				slot_used[own][slot] = 1'b1;
			end else begin
				pending = 1'b1;
			end
		end
		cnt = pending ? 1 : 0;
		for (i = 0; i < DEPTH; i++)
			if (slot_used[own][i])
				cnt++;
		while (cnt > lim) begin
			m = -1;
			for (i = 0; i < DEPTH; i++)
				if (slot_used[own][i] && (m < 0 || stamp_tab[own][i] < stamp_tab[own][m]))
					m = i;
			// On a full table the new stamp competes with the smallest held one.
			if (pending && (m < 0 || s < stamp_tab[own][m])) begin
				d = s;
				pending = 1'b0;
			end else if (m >= 0) begin
				d = stamp_tab[own][m];
				if (pending) begin
					stamp_tab[own][m] = s;
					pending = 1'b0;
				end else begin
					slot_used[own][m] = 1'b0;
				end
			end else begin
				break;
			end
			if (drops == 0)
				res.dstamp = d;
			drops++;
			cnt--;
		end
		res.dcount = (drops > int'(DROP_CNT_MAX)) ? DROP_CNT_MAX : DROP_CNT_W'(drops);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pair_outcome_t want;
		int            i;
		if (!arst_n) begin
			for (i = 0; i < DEPTH; i++) begin
				slot_used[0][i] = 1'b0;
				slot_used[1][i] = 1'b0;
			end
			held_limit = MAX_HELD_RESET;
			outcomes_q.delete();
			awaiting <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (outcomes_q.size() == 0) begin
					flag_mismatch("unexpected result beat", 64'd0, 64'd1);
				end else begin
					want = outcomes_q.pop_front();
					if (inserted !== want.ins)
						flag_mismatch("inserted", 64'(want.ins), 64'(inserted));
					if (matched !== want.mat)
						flag_mismatch("matched", 64'(want.mat), 64'(matched));
					if (dropped_count !== want.dcount)
						flag_mismatch("dropped_count", 64'(want.dcount), 64'(dropped_count));
					if (first_drop !== want.dstamp)
						flag_mismatch("first_drop", 64'(want.dstamp), 64'(first_drop));
				end
			end
			if (in_valid && in_ready)
				outcomes_q = {outcomes_q, pair_and_trim(action, stamp, pose_valid)};
			if (psel && penable && pready && paddr[2] == REG_MAX_HELD) begin
				if (pwrite)
					held_limit = pwdata[CFG_W-1:0];
				else if (prdata[CFG_W-1:0] !== held_limit)
					flag_mismatch("max_held readback", 64'(held_limit),
						64'(prdata[CFG_W-1:0]));
			end
			awaiting <= outcomes_q.size();
		end
	end

endmodule

@@ sim/tb_exact_stamp_pair_matcher.sv @@
// Testbench top for the exact stamp pair matcher: clock, reset, APB writes of max_held,
// input and result traffic with idling and a long receiver hold-off, and the verdict.
// Depends on espm_pkg, exact_stamp_pair_matcher and stamp_pair_checker.
`timescale 1ns / 1ps

module tb_exact_stamp_pair_matcher;
	import espm_pkg::*;

	// Idling patterns applied per phase of the run.
	typedef enum int {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_t;

	localparam logic ACT_POSE = 1'b0;
	localparam logic ACT_SCAN = 1'b1;

	// All bits set, and an alternating pattern; with zero and the complement of the
	// pattern these drive every stamp bit both ways in the opening part.
	localparam logic [STAMP_W-1:0] STAMP_TOP = '1;
	localparam logic [STAMP_W-1:0] STAMP_ALT = 63'h2AAA_AAAA_AAAA_AAAA;

	// Every beat yields a result, so once nothing is awaited only a short settle is needed.
	localparam int SETTLE_CYCLES   = 12;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int RECENT_DEPTH    = 12;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [PADDR_W-1:0]    paddr;
	logic [PDATA_W-1:0]    pwdata;
	logic [PDATA_W-1:0]    prdata;
	logic                  pready;
	logic                  in_valid;
	logic                  in_ready;
	logic                  action;
	logic [STAMP_W-1:0]    stamp;
	logic                  pose_valid;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  inserted;
	logic                  matched;
	logic [DROP_CNT_W-1:0] dropped_count;
	logic [STAMP_W-1:0]    first_drop;

	int mismatches;
	int awaiting;

	int send_idle_pct;
	int recv_stall_pct;
	bit hold_request;
	bit hold_done;
	int hold_left;
	int beats_sent;

	// Recently sent stamps per stream, the source of matches and repeats.
	logic [STAMP_W-1:0] recent_pose [$];
	logic [STAMP_W-1:0] recent_scan [$];
	// Sensor time that advances like a real clock between arrivals.
	logic [STAMP_W-1:0] sensor_now;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	exact_stamp_pair_matcher u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.stamp         (stamp),
		.pose_valid    (pose_valid),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.inserted      (inserted),
		.matched       (matched),
		.dropped_count (dropped_count),
		.first_drop    (first_drop)
	);

	stamp_pair_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.stamp         (stamp),
		.pose_valid    (pose_valid),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.inserted      (inserted),
		.matched       (matched),
		.dropped_count (dropped_count),
		.first_drop    (first_drop),
		.mismatches    (mismatches),
		.awaiting      (awaiting)
	);

	// Result side. A hold-off, once requested, keeps out_ready low until hold_left has counted
	// down while the sender keeps offering beats, so the block backs up and has to
	// stall its input. Otherwise out_ready follows the stall rate of the phase.
	always @(posedge clk) begin
		if (hold_request && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_OFF_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Generous fixed limit, far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic set_idle(input idle_mode_t mode);
		send_idle_pct  = (mode == IDLE_SEND) ? 65 : (mode == IDLE_BOTH) ? 30 : 0;
		recv_stall_pct = (mode == IDLE_RECV) ? 65 : (mode == IDLE_BOTH) ? 30 : 0;
	endtask

	// One APB transfer to max_held: setup, access until pready, then an idle bus before returning.
	// Writes carry random upper data bits, which the 7-bit register must ignore.
	task automatic apb_access(input bit wr, input logic [CFG_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {REG_MAX_HELD, 2'b00};
		pwdata  <= {(PDATA_W-CFG_W)'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Offers one beat after a random gap and returns at the edge that accepts it.
	// Valid stays high on return so back-to-back beats need no bubble.
	task automatic send_beat(input logic is_scan, input logic [STAMP_W-1:0] s,
		input logic valid);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		action     <= is_scan;
		stamp      <= s;
		pose_valid <= valid;
		do @(posedge clk); while (!in_ready);
		beats_sent++;
		// A discarded pose never reaches a table, so it is no source of matches.
		if (is_scan) begin
			recent_scan = {recent_scan, s};
			if (recent_scan.size() > RECENT_DEPTH)
				void'(recent_scan.pop_front());
		end else if (valid) begin
			recent_pose = {recent_pose, s};
			if (recent_pose.size() > RECENT_DEPTH)
				void'(recent_pose.pop_front());
		end
	endtask

	// Stops offering and waits until every result has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaiting != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly advancing sensor time, sometimes tiny stamps or anything in range.
	function automatic logic [STAMP_W-1:0] fresh_stamp();
		case ($urandom_range(9))
			0: return STAMP_W'({$urandom, $urandom});
			1: return STAMP_W'($urandom_range(15));
			default: begin
				sensor_now = sensor_now + STAMP_W'($urandom_range(5000, 1));
				return sensor_now;
			end
		endcase
	endfunction

	// A stamp that the other stream has seen is likely to pair; one from the same
	// stream exercises replacement of an equal stamp.
	function automatic logic [STAMP_W-1:0] pick_stamp(input logic is_scan);
		int r;
		r = $urandom_range(99);
		if (r < 35 && is_scan && recent_pose.size() != 0)
			return recent_pose[$urandom_range(recent_pose.size() - 1)];
		if (r < 35 && !is_scan && recent_scan.size() != 0)
			return recent_scan[$urandom_range(recent_scan.size() - 1)];
		if (r < 45 && is_scan && recent_scan.size() != 0)
			return recent_scan[$urandom_range(recent_scan.size() - 1)];
		if (r < 45 && !is_scan && recent_pose.size() != 0)
			return recent_pose[$urandom_range(recent_pose.size() - 1)];
		return fresh_stamp();
	endfunction

	task automatic stray_beat();
		logic is_scan;
		is_scan = 1'($urandom_range(1));
		send_beat(is_scan, pick_stamp(is_scan), 1'($urandom_range(9) != 0));
	endtask

	// The normal case: a few stamps seen on one stream and then, in shuffled order,
	// on the other, now and then with a stray beat in between.
	task automatic paired_run();
		logic [STAMP_W-1:0] run [$];
		logic [STAMP_W-1:0] tmp;
		logic               first;
		int                 n, i, j;
		n = $urandom_range(6, 1);
		first = 1'($urandom_range(1));
		for (i = 0; i < n; i++)
			run = {run, fresh_stamp()};
		for (i = 0; i < n; i++) begin
			send_beat(first, run[i], 1'($urandom_range(9) != 0));
			if ($urandom_range(7) == 0)
				stray_beat();
		end
		for (i = n - 1; i > 0; i--) begin
			j = $urandom_range(i);
			tmp = run[i];
			run[i] = run[j];
			run[j] = tmp;
		end
		for (i = 0; i < n; i++) begin
			send_beat(!first, run[i], 1'($urandom_range(9) != 0));
			if ($urandom_range(7) == 0)
				stray_beat();
		end
	endtask

	// One phase: set the limit while idle, read it back, then traffic. A flood phase
	// sends only valid poses and no scans so that the pose table runs full.
	task automatic run_phase(input logic [CFG_W-1:0] limit, input idle_mode_t mode,
		input int count, input bit flood);
		int start;
		apb_access(1'b1, limit);
		apb_access(1'b0, limit);
		set_idle(mode);
		start = beats_sent;
		while (beats_sent - start < count) begin
			if (flood)
				send_beat(ACT_POSE, ($urandom_range(1) != 0) ? STAMP_W'($urandom_range(2000))
					: STAMP_W'({$urandom, $urandom}), 1'b1);
			else if ($urandom_range(99) < 60)
				paired_run();
			else
				stray_beat();
		end
		drain_results();
	endtask

	initial begin
		arst_n     <= 1'b0;
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		paddr      <= '0;
		pwdata     <= '0;
		in_valid   <= 1'b0;
		action     <= ACT_POSE;
		stamp      <= '0;
		pose_valid <= 1'b0;
		sensor_now = STAMP_W'(1_000_000);
		set_idle(IDLE_NONE);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Opening part at the reset limit: extreme stamps, pairing both ways, equal stamps
		// replaced, invalid poses discarded, and pose_valid ignored on scans.
		send_beat(ACT_POSE, '0, 1'b1);
		send_beat(ACT_SCAN, '0, 1'b1);
		send_beat(ACT_POSE, STAMP_TOP, 1'b1);
		send_beat(ACT_POSE, STAMP_TOP, 1'b1);
		send_beat(ACT_SCAN, STAMP_TOP, 1'b0);
		send_beat(ACT_POSE, STAMP_ALT, 1'b0);
		send_beat(ACT_SCAN, STAMP_ALT, 1'b1);
		send_beat(ACT_POSE, STAMP_ALT, 1'b0);
		send_beat(ACT_POSE, STAMP_ALT, 1'b1);
		send_beat(ACT_SCAN, ~STAMP_ALT, 1'b0);
		send_beat(ACT_SCAN, ~STAMP_ALT, 1'b1);
		send_beat(ACT_POSE, ~STAMP_ALT, 1'b1);
		drain_results();

		// Smallest limit: trimming, including a new stamp that is itself the smallest.
		apb_access(1'b1, CFG_W'(2));
		send_beat(ACT_POSE, STAMP_W'(30), 1'b1);
		send_beat(ACT_POSE, STAMP_W'(20), 1'b1);
		send_beat(ACT_POSE, STAMP_W'(10), 1'b1);
		send_beat(ACT_POSE, STAMP_W'(40), 1'b1);
		send_beat(ACT_SCAN, STAMP_W'(20), 1'b1);
		send_beat(ACT_SCAN, STAMP_W'(30), 1'b1);
		send_beat(ACT_SCAN, STAMP_W'(40), 1'b1);
		send_beat(ACT_SCAN, STAMP_W'(5), 1'b1);
		send_beat(ACT_SCAN, STAMP_W'(1), 1'b1);
		drain_results();

		// Random phases over the limit range, including values clamped up and down.
		run_phase(CFG_W'(100), IDLE_NONE, 50, 1'b0);
		run_phase(CFG_W'(0), IDLE_SEND, 40, 1'b0);
		run_phase(CFG_W'(1), IDLE_RECV, 40, 1'b0);
		run_phase(CFG_W'(7), IDLE_BOTH, 40, 1'b0);

		// Flood the pose table past its depth while the receiver holds off for a long
		// stretch; the top limit value clamps to the full depth.
		hold_request = 1'b1;
		run_phase(CFG_W'(127), IDLE_NONE, 80, 1'b1);

		// Shrinking the limit on a full table makes the next pose drop nearly all of it.
		apb_access(1'b1, CFG_W'(2));
		set_idle(IDLE_BOTH);
		send_beat(ACT_POSE, fresh_stamp(), 1'b1);
		drain_results();
		run_phase(CFG_W'(2), IDLE_BOTH, 40, 1'b0);
		run_phase(CFG_W'(64), IDLE_SEND, 50, 1'b0);
		run_phase(CFG_W'(33), IDLE_RECV, 50, 1'b0);
		run_phase(CFG_W'(3), IDLE_NONE, 30, 1'b0);

		if (mismatches == 0 && awaiting == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
